>>> rtl/wmcd_pkg.sv
package wmcd_pkg;

    localparam int DIGIT_COUNT = 10;
    localparam int DIGIT_W     = 4;
    localparam int ACCT_W      = DIGIT_COUNT * DIGIT_W;
    localparam int PROD_W      = 2 * DIGIT_W;
    localparam int HALF_W      = 11;
    localparam int SUM_W       = 12;
    localparam int HALF_SPLIT  = 6;
    localparam int CFG_IDX_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_SUM = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_POS = 8'd3;

    localparam logic [3:0] MODULUS_RST   = 4'd11;
    localparam logic [3:0] CHECK_POS_RST = 4'd10;

    typedef logic [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               pos_ok;
    } wmcd_side_t;

    function automatic logic [DIGIT_W-1:0] nibble_at(input logic [ACCT_W-1:0] packed_in,
                                                     input int idx);
        return packed_in[ACCT_W-1-idx*DIGIT_W -: DIGIT_W];
    endfunction

    // tens plus units; quotient by 10 through reciprocal 205/2048, exact below 1029
    function automatic logic [4:0] cross_sum(input prod_t p);
        logic [15:0] recip;
        logic [4:0]  q;
        logic [7:0]  u;
        recip = 16'(p) * 16'd205;
        q     = recip[15:11];
        u     = p - (8'(q) * 8'd10);
        return 5'(q + u[4:0]);
    endfunction

    // restoring remainder over HALF_SPLIT bits, MSB first; r stays below m
    function automatic logic [3:0] rem_steps(input logic [3:0] r_in,
                                             input logic [HALF_SPLIT-1:0] bits,
                                             input logic [3:0] m);
        logic [3:0] r;
        logic [4:0] t;
        r = r_in;
        for (int i = HALF_SPLIT - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, m}) begin
                t = t - {1'b0, m};
            end
            r = t[3:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/weighted_modulus_check_digit_unit.sv
// Channel   Ports          Payload
// input     s_axis_*       tdata[39:0] account_digits
// result    m_axis_*       tdata[0] check_ok, tdata[4:1] expected_digit
// config    cfg_*          0 modulus, 1 digit_weights, 2 cross_sum_enable, 3 check_position
// One transaction per cycle while the output is not stalled; stages in order: products, cross sum and half sums,
// total, two remainder stages, check digit and compare.
// Synchronous active-low reset clears the valid bits and loads the register defaults.
// Each stage holds while the one after it is full and stalled; nothing is dropped.
module weighted_modulus_check_digit_unit
    import wmcd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ACCT_W-1:0]    s_axis_tdata,   // [39:0] account_digits
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [0] check_ok, [4:1] expected_digit, [7:5] zero
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ACCT_W-1:0]    cfg_wdata
);

    logic [3:0]        modulus_reg;
    logic [ACCT_W-1:0] weights_reg;
    logic              cross_sum_reg;
    logic [3:0]        check_pos_reg;
    logic [3:0]        mod_eff;

    logic              v1_reg;
    prod_t             prod_reg [DIGIT_COUNT];
    wmcd_side_t        side1_reg;
    logic              v2_reg;
    logic [HALF_W-1:0] half_hi_reg;
    logic [HALF_W-1:0] half_lo_reg;
    wmcd_side_t        side2_reg;
    logic              v3_reg;
    logic [SUM_W-1:0]  sum_reg;
    wmcd_side_t        side3_reg;
    logic              v6_reg;
    logic              ok_reg;
    logic [3:0]        expected_reg;

    logic              r1;
    logic              r2;
    logic              r3;
    logic              r6;
    logic              red_in_ready;
    logic              red_out_valid;
    logic [3:0]        red_rem;
    wmcd_side_t        red_side;

    wmcd_side_t        side1_next;
    logic [HALF_W-1:0] half_hi_next;
    logic [HALF_W-1:0] half_lo_next;
    logic [4:0]        diff;
    logic [3:0]        expected_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg   <= MODULUS_RST;
            weights_reg   <= '0;
            cross_sum_reg <= 1'b0;
            check_pos_reg <= CHECK_POS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODULUS:   modulus_reg   <= cfg_wdata[3:0];
                REG_WEIGHTS:   weights_reg   <= cfg_wdata;
                REG_CROSS_SUM: cross_sum_reg <= cfg_wdata[0];
                REG_CHECK_POS: check_pos_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign mod_eff = (modulus_reg == 4'd0) ? 4'd1 : modulus_reg;

    assign r6 = !v6_reg || m_axis_tready;
    assign r3 = !v3_reg || red_in_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign s_axis_tready = r1;

    always_comb begin
        side1_next.digit  = '0;
        side1_next.pos_ok = 1'b0;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (check_pos_reg == 4'(i + 1)) begin
                side1_next.digit  = nibble_at(s_axis_tdata, i);
                side1_next.pos_ok = 1'b1;
            end
        end
    end

    always_comb begin
        logic [4:0] cs;
        half_hi_next = '0;
        half_lo_next = '0;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            cs = cross_sum(prod_reg[i]);
            if (i < DIGIT_COUNT / 2) begin
                half_hi_next = half_hi_next +
                    (cross_sum_reg ? HALF_W'(cs) : HALF_W'(prod_reg[i]));
            end else begin
                half_lo_next = half_lo_next +
                    (cross_sum_reg ? HALF_W'(cs) : HALF_W'(prod_reg[i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= s_axis_tvalid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
            if (r6) begin
                v6_reg <= red_out_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                prod_reg[i] <= PROD_W'(nibble_at(s_axis_tdata, i))
                             * PROD_W'(nibble_at(weights_reg, i));
            end
            side1_reg <= side1_next;
        end
        if (r2) begin
            half_hi_reg <= half_hi_next;
            half_lo_reg <= half_lo_next;
            side2_reg   <= side1_reg;
        end
        if (r3) begin
            sum_reg   <= SUM_W'(half_hi_reg) + SUM_W'(half_lo_reg);
            side3_reg <= side2_reg;
        end
        if (r6) begin
            ok_reg       <= red_side.pos_ok && (red_side.digit == expected_next);
            expected_reg <= expected_next;
        end
    end

    wmcd_reduce u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3_reg),
        .in_ready  (red_in_ready),
        .in_sum    (sum_reg),
        .in_side   (side3_reg),
        .modulus   (mod_eff),
        .out_valid (red_out_valid),
        .out_ready (r6),
        .out_rem   (red_rem),
        .out_side  (red_side)
    );

    always_comb begin
        diff = {1'b0, mod_eff} - {1'b0, red_rem};
        if (red_rem == 4'd0) begin
            expected_next = 4'd0;
        end else if (diff >= 5'd10) begin
            expected_next = 4'(diff - 5'd10);
        end else begin
            expected_next = diff[3:0];
        end
    end

    assign m_axis_tvalid = v6_reg;
    assign m_axis_tdata  = {3'b000, expected_reg, ok_reg};

endmodule

>>> rtl/wmcd_reduce.sv
module wmcd_reduce
    import wmcd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [SUM_W-1:0] in_sum,
    input  wmcd_side_t       in_side,
    input  logic [3:0]       modulus,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [3:0]       out_rem,
    output wmcd_side_t       out_side
);

    logic                  a_valid_reg;
    logic [3:0]            a_rem_reg;
    logic [HALF_SPLIT-1:0] a_low_reg;
    wmcd_side_t            a_side_reg;
    logic                  b_valid_reg;
    logic [3:0]            b_rem_reg;
    wmcd_side_t            b_side_reg;
    logic                  a_ready;
    logic                  b_ready;
    logic [3:0]            a_rem_next;
    logic [3:0]            b_rem_next;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_rem_next = rem_steps(4'd0, in_sum[SUM_W-1 -: HALF_SPLIT], modulus);
    assign b_rem_next = rem_steps(a_rem_reg, a_low_reg, modulus);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_rem_reg  <= a_rem_next;
            a_low_reg  <= in_sum[HALF_SPLIT-1:0];
            a_side_reg <= in_side;
        end
        if (b_ready) begin
            b_rem_reg  <= b_rem_next;
            b_side_reg <= a_side_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_rem   = b_rem_reg;
    assign out_side  = b_side_reg;

endmodule

>>> dv/weighted_modulus_check_digit_unit_tb.sv
module weighted_modulus_check_digit_unit_tb;
    import wmcd_pkg::*;

    localparam int IDLE_PCT    = 29;
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 12;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] digit;
    } check_result_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [ACCT_W-1:0]    s_axis_tdata  = '0;   // [39:0] account_digits
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // [0] check_ok, [4:1] expected_digit
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [ACCT_W-1:0]    cfg_wdata     = '0;

    logic [3:0]        modulus_q   = MODULUS_RST;
    logic [ACCT_W-1:0] weights_q   = '0;
    logic              cross_sum_q = 1'b0;
    logic [3:0]        check_pos_q = CHECK_POS_RST;

    check_result_t pending_checks[$];
    int unsigned   accounts_sent   = 0;
    int unsigned   results_seen    = 0;
    int unsigned   matches_seen    = 0;
    int unsigned   error_count     = 0;
    int unsigned   quiet_cycles    = 0;
    int            hold_left       = 0;
    bit            hold_request    = 1'b0;
    bit            sender_steady   = 1'b0;
    bit            receiver_steady = 1'b0;

    weighted_modulus_check_digit_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [ACCT_W-1:0] word,
                                                    input int unsigned idx);
        return DIGIT_W'(word >> ((DIGIT_COUNT - 1 - idx) * DIGIT_W));
    endfunction

    function automatic logic [ACCT_W-1:0] put_digit(input logic [ACCT_W-1:0] word,
                                                    input int unsigned idx,
                                                    input logic [DIGIT_W-1:0] d);
        int unsigned sh;
        sh = (DIGIT_COUNT - 1 - idx) * DIGIT_W;
        return (word & ~(ACCT_W'(4'hF) << sh)) | (ACCT_W'(d) << sh);
    endfunction

    function automatic check_result_t predict_check_digit(input logic [ACCT_W-1:0] acct);
        int unsigned   m;
        int unsigned   total;
        int unsigned   term;
        int unsigned   rem;
        int unsigned   i;
        check_result_t r;
        m     = (modulus_q == 0) ? 1 : modulus_q;
        total = 0;
        for (i = 0; i < DIGIT_COUNT; i++) begin
            term = digit_of(acct, i) * digit_of(weights_q, i);
            if (cross_sum_q) begin
                term = term / 10 + term % 10;
            end
            total += term;
        end
        rem = total % m;
        if (rem == 0) begin
            rem = m;
        end
        r.digit = DIGIT_W'((m - rem) % 10);
        r.ok    = 1'b0;
        if (check_pos_q >= 1 && check_pos_q <= DIGIT_COUNT) begin
            r.ok = (digit_of(acct, check_pos_q - 1) == r.digit);
        end
        return r;
    endfunction

    // mostly valid BCD with the check digit filled in, some plain BCD, some raw noise
    function automatic logic [ACCT_W-1:0] random_account(input int unsigned shape);
        logic [ACCT_W-1:0] acct;
        check_result_t     want;
        int unsigned       i;
        if (shape < 15) begin
            return ACCT_W'({$urandom, $urandom});
        end
        acct = '0;
        for (i = 0; i < DIGIT_COUNT; i++) begin
            acct = put_digit(acct, i, DIGIT_W'($urandom_range(9)));
        end
        if (shape >= 40 && check_pos_q >= 1 && check_pos_q <= DIGIT_COUNT) begin
            want = predict_check_digit(acct);
            acct = put_digit(acct, check_pos_q - 1, want.digit);
        end
        return acct;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ACCT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_MODULUS:   modulus_q   = value[3:0];
            REG_WEIGHTS:   weights_q   = value;
            REG_CROSS_SUM: cross_sum_q = value[0];
            REG_CHECK_POS: check_pos_q = value[3:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [ACCT_W-1:0] mod_word,
                                  input logic [ACCT_W-1:0] weight_word,
                                  input logic [ACCT_W-1:0] cross_word,
                                  input logic [ACCT_W-1:0] pos_word);
        write_reg(REG_MODULUS, mod_word);
        write_reg(REG_WEIGHTS, weight_word);
        write_reg(REG_CROSS_SUM, cross_word);
        write_reg(REG_CHECK_POS, pos_word);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // upper bits of the modulus, cross-sum and position words are random; the block must drop them
    task automatic random_settings();
        logic [ACCT_W-1:0] weights;
        int unsigned       pos;
        weights = ACCT_W'({$urandom, $urandom});
        pos     = $urandom_range(1, DIGIT_COUNT);
        if ($urandom_range(99) < 75) begin
            weights = put_digit(weights, pos - 1, '0);
        end
        apply_settings({ACCT_W'($urandom) & ~ACCT_W'(4'hF)} | ACCT_W'($urandom_range(2, 15)),
                       weights,
                       ACCT_W'({$urandom, $urandom}),
                       {ACCT_W'($urandom) & ~ACCT_W'(4'hF)} | ACCT_W'(pos));
    endtask

    task automatic send_account(input logic [ACCT_W-1:0] acct);
        while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= acct;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        pending_checks.push_back(predict_check_digit(acct));
        accounts_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_checks.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic check_result();
        check_result_t want;
        check_result_t got;
        got.ok    = m_axis_tdata[0];
        got.digit = m_axis_tdata[4:1];
        results_seen++;
        if (pending_checks.size() == 0) begin
            $display("%0t: unexpected transaction ok=%0b digit=%0d", $time, got.ok, got.digit);
            error_count++;
        end else begin
            want = pending_checks.pop_front();
            if (got.ok !== want.ok) begin
                $display("%0t: check_ok expected %0b actual %0b", $time, want.ok, got.ok);
                error_count++;
            end
            if (got.digit !== want.digit) begin
                $display("%0t: expected_digit expected %0d actual %0d",
                         $time, want.digit, got.digit);
                error_count++;
            end
            if (want.ok) begin
                matches_seen++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= receiver_steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("weighted_modulus_check_digit_unit_tb: errors");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_account(40'h00_0000_0000);
        send_account(40'h99_9999_9999);
        send_account(40'h12_3456_7890);
        wait_drained();
    endtask

    task automatic test_extreme_settings();
        apply_settings(40'd15, 40'hFF_FFFF_FFFF, 40'd1, 40'd1);
        send_account(40'hFF_FFFF_FFFF);
        send_account(40'h99_9999_9999);
        send_account(40'h00_0000_0000);
        wait_drained();
        apply_settings(40'd2, 40'h00_0000_0000, 40'd0, 40'd10);
        send_account(40'h55_5555_5555);
        send_account(40'hAA_AAAA_AAAA);
        wait_drained();
    endtask

    task automatic test_modulus_corners();
        apply_settings(40'd0, 40'h21_2121_2121, 40'd0, 40'd10);
        send_account(40'h12_3456_7890);
        send_account(40'h09_8765_4321);
        wait_drained();
        apply_settings(40'd1, 40'h37_3737_3737, 40'd1, 40'd10);
        send_account(40'h12_3456_7890);
        send_account(40'h09_8765_4320);
        wait_drained();
    endtask

    task automatic test_check_position_corners();
        apply_settings(40'd10, 40'h12_3456_7890, 40'd0, 40'd0);
        send_account(40'h00_0000_0000);
        wait_drained();
        apply_settings(40'd10, 40'h12_3456_7890, 40'd0, 40'd11);
        send_account(40'h00_0000_0000);
        wait_drained();
        apply_settings(40'd10, 40'h12_3456_7890, 40'd0, 40'd15);
        send_account(40'h00_0000_0000);
        wait_drained();
    endtask

    task automatic test_ignored_index();
        apply_settings(40'd11, 40'h98_7654_3210, 40'd0, 40'd10);
        write_reg(CFG_IDX_W'($urandom_range(REG_CHECK_POS + 1, 255)),
                  ACCT_W'({$urandom, $urandom}));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        send_account(40'h12_3456_7890);
        send_account(random_account(99));
        wait_drained();
    endtask

    task automatic test_random_settings();
        repeat (6) begin
            random_settings();
            repeat (45) send_account(random_account($urandom_range(99)));
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        random_settings();
        sender_steady = 1'b1;
        hold_request  = 1'b1;
        repeat (30) send_account(random_account($urandom_range(99)));
        sender_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_steady_stream();
        random_settings();
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        repeat (100) send_account(random_account($urandom_range(99)));
        wait_drained();
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_extreme_settings();
        test_modulus_corners();
        test_check_position_corners();
        test_ignored_index();
        test_random_settings();
        test_backpressure();
        test_steady_stream();
        $display("accounts checked: %0d, results received: %0d, digit matches: %0d",
                 accounts_sent, results_seen, matches_seen);
        $display("covered register extremes, odd moduli and positions, stalls and a full-rate run");
        if (error_count == 0 && pending_checks.size() == 0) begin
            $display("weighted_modulus_check_digit_unit_tb: clean");
        end else begin
            $display("weighted_modulus_check_digit_unit_tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/wmcd_pkg.sv
rtl/wmcd_reduce.sv
rtl/weighted_modulus_check_digit_unit.sv
dv/weighted_modulus_check_digit_unit_tb.sv
